// ===== rtl/asd_pkg.sv =====
// Package with the shared types and constants of the accelerometer shake detector.
package asd_pkg;

  localparam int AXIS_W  = 16;
  localparam int DELTA_W = 18;
  localparam int TICK_W  = 32;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DELTA_THRESHOLD = 3'd0;
  localparam cfg_idx_t CFG_REQUIRED_HITS   = 3'd1;
  localparam cfg_idx_t CFG_COOLDOWN_TICKS  = 3'd2;
  localparam cfg_idx_t CFG_SETTLE_SAMPLES  = 3'd3;
  localparam cfg_idx_t CFG_FAILURE_LIMIT   = 3'd4;

  localparam logic [DELTA_W-1:0] RST_DELTA_THRESHOLD = 18'd8000;
  localparam logic [CNT_W-1:0]   RST_REQUIRED_HITS   = 8'd3;
  localparam logic [TICK_W-1:0]  RST_COOLDOWN_TICKS  = 32'd1500;
  localparam logic [CNT_W-1:0]   RST_SETTLE_SAMPLES  = 8'd10;
  localparam logic [CNT_W-1:0]   RST_FAILURE_LIMIT   = 8'd3;

  localparam logic [CNT_W-1:0]   CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CLS_FAIL      = 2'd0,
    CLS_GOOD_NEW  = 2'd1,
    CLS_GOOD_PREV = 2'd2
  } item_cls_t;

  typedef struct packed {
    item_cls_t           cls;
    logic [DELTA_W-1:0]  delta;
    logic [TICK_W-1:0]   now_tick;
  } queue_entry_t;

  typedef struct packed {
    logic [DELTA_W-1:0]  delta_threshold;
    logic [CNT_W-1:0]    required_hits;
    logic [TICK_W-1:0]   cooldown_ticks;
    logic [CNT_W-1:0]    settle_samples;
    logic [CNT_W-1:0]    failure_limit;
  } cfg_t;

  typedef struct packed {
    logic                shake;
    logic                reinit_request;
    logic [DELTA_W-1:0]  motion_delta;
    logic                settling;
  } result_t;

endpackage

// ===== rtl/accel_shake_detector.sv =====
// Top level of the accelerometer shake detector with its configuration registers.
//
//   channel | handshake           | payload
//   in      | in_valid/in_stall   | read_ok, accel_x/y/z, now_tick
//   out     | out_valid/out_stall | shake, reinit_request, motion_delta, settling
//   cfg     | cfg_we              | cfg_index, cfg_wdata
//
// One request is accepted per cycle while in_stall is low.
// The front stage registers requests into a queue of QUEUE_DEPTH entries, and the
// back stage updates its state once per request as it loads the result register.
// in_stall rises only when the queue is full; out_stall holds the result register.
// Reset is synchronous; no clearing pass follows.
module accel_shake_detector import asd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_read_ok,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  input  logic [TICK_W-1:0]        in_now_tick,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_shake,
  output logic                     out_reinit_request,
  output logic [DELTA_W-1:0]       out_motion_delta,
  output logic                     out_settling
);

  cfg_t         cfg_r;
  logic         q_push, q_full;
  queue_entry_t wr_entry, rd_entry;
  logic         q_empty, q_pop;
  result_t      res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delta_threshold <= RST_DELTA_THRESHOLD;
      cfg_r.required_hits   <= RST_REQUIRED_HITS;
      cfg_r.cooldown_ticks  <= RST_COOLDOWN_TICKS;
      cfg_r.settle_samples  <= RST_SETTLE_SAMPLES;
      cfg_r.failure_limit   <= RST_FAILURE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELTA_THRESHOLD: cfg_r.delta_threshold <= cfg_wdata[DELTA_W-1:0];
        CFG_REQUIRED_HITS:   cfg_r.required_hits   <= cfg_wdata[CNT_W-1:0];
        CFG_COOLDOWN_TICKS:  cfg_r.cooldown_ticks  <= cfg_wdata[TICK_W-1:0];
        CFG_SETTLE_SAMPLES:  cfg_r.settle_samples  <= cfg_wdata[CNT_W-1:0];
        CFG_FAILURE_LIMIT:   cfg_r.failure_limit   <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;

  asd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_queue_full (q_full),
    .in_read_ok    (in_read_ok),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_now_tick   (in_now_tick),
    .push          (q_push),
    .entry         (wr_entry)
  );

  asd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .full     (q_full),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_entry (rd_entry)
  );

  asd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_entry   (rd_entry),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_shake          = res.shake;
  assign out_reinit_request = res.reinit_request;
  assign out_motion_delta   = res.motion_delta;
  assign out_settling       = res.settling;

endmodule

// ===== rtl/asd_front.sv =====
// Front stage: accepts requests, tracks the previous sample and computes the axis delta.
module asd_front import asd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_queue_full,
  input  logic                     in_read_ok,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  input  logic [TICK_W-1:0]        in_now_tick,
  output logic                     push,
  output queue_entry_t             entry
);

  logic signed [AXIS_W-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                     have_prev_r;
  logic [AXIS_W-1:0]        dx, dy, dz;

  function automatic logic [AXIS_W-1:0] abs_diff(input logic signed [AXIS_W-1:0] a,
                                                 input logic signed [AXIS_W-1:0] b);
    logic signed [AXIS_W:0] d;
    logic        [AXIS_W:0] m;
    d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
    m = d[AXIS_W] ? (~d + 1'b1) : d;
    return m[AXIS_W-1:0];
  endfunction

  assign push = in_valid && !in_queue_full;

  always_comb begin
    dx = abs_diff(in_accel_x, prev_x_r);
    dy = abs_diff(in_accel_y, prev_y_r);
    dz = abs_diff(in_accel_z, prev_z_r);
    entry.delta    = {2'b00, dx} + {2'b00, dy} + {2'b00, dz};
    entry.now_tick = in_now_tick;
    if (!in_read_ok) begin
      entry.cls = CLS_FAIL;
    end else if (have_prev_r) begin
      entry.cls = CLS_GOOD_PREV;
    end else begin
      entry.cls = CLS_GOOD_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
    end else if (push) begin
      have_prev_r <= in_read_ok;
      if (in_read_ok) begin
        prev_x_r <= in_accel_x;
        prev_y_r <= in_accel_y;
        prev_z_r <= in_accel_z;
      end
    end
  end

endmodule

// ===== rtl/asd_queue.sv =====
// Short request queue between the front stage and the back stage.
module asd_queue import asd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  queue_entry_t wr_entry,
  input  logic         pop,
  output logic         empty,
  output queue_entry_t rd_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  queue_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  count_r;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue pushed while full");
`endif

endmodule

// ===== rtl/asd_back.sv =====
// Back stage: failure, settle, hit and cooldown tracking plus the result register.
module asd_back import asd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         q_empty,
  input  queue_entry_t q_entry,
  output logic         q_pop,
  input  logic         out_stall,
  output logic         out_valid,
  output result_t      out_res
);

  logic [CNT_W-1:0]  settle_left_r, settle_left_nxt;
  logic [CNT_W-1:0]  hit_run_r, hit_run_nxt;
  logic [CNT_W-1:0]  fail_run_r, fail_run_nxt;
  logic [TICK_W-1:0] last_shake_r, last_shake_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;
  logic [CNT_W-1:0]  fail_inc, hit_inc;
  logic [TICK_W-1:0] since_shake;
  logic              cool;

  assign q_pop     = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    settle_left_nxt = settle_left_r;
    hit_run_nxt     = hit_run_r;
    fail_run_nxt    = fail_run_r;
    last_shake_nxt  = last_shake_r;
    out_nxt         = '0;
    fail_inc        = (fail_run_r == CNT_MAX) ? fail_run_r : fail_run_r + 1'b1;
    hit_inc         = (hit_run_r == CNT_MAX) ? hit_run_r : hit_run_r + 1'b1;
    since_shake     = q_entry.now_tick - last_shake_r;
    cool            = (since_shake >= cfg.cooldown_ticks);
    if (q_entry.cls == CLS_FAIL) begin
      hit_run_nxt  = '0;
      fail_run_nxt = fail_inc;
      if (fail_inc >= cfg.failure_limit) begin
        out_nxt.reinit_request = 1'b1;
        fail_run_nxt           = '0;
        settle_left_nxt        = cfg.settle_samples;
      end
    end else begin
      fail_run_nxt = '0;
      if (settle_left_r != '0) begin
        settle_left_nxt  = settle_left_r - 1'b1;
        out_nxt.settling = 1'b1;
      end else if (q_entry.cls == CLS_GOOD_PREV) begin
        out_nxt.motion_delta = q_entry.delta;
        hit_run_nxt = (q_entry.delta >= cfg.delta_threshold) ? hit_inc : '0;
        if (hit_run_nxt >= cfg.required_hits && cool) begin
          out_nxt.shake  = 1'b1;
          last_shake_nxt = q_entry.now_tick;
          hit_run_nxt    = '0;
        end
      end
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_left_r <= RST_SETTLE_SAMPLES;
      hit_run_r     <= '0;
      fail_run_r    <= '0;
      last_shake_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        settle_left_r <= settle_left_nxt;
        hit_run_r     <= hit_run_nxt;
        fail_run_r    <= fail_run_nxt;
        last_shake_r  <= last_shake_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_shake_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.shake |-> !out_r.reinit_request && !out_r.settling)
    else $error("shake reported together with reinit or settling");
  a_settle_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.settling || out_r.reinit_request) |-> out_r.motion_delta == '0)
    else $error("motion delta reported on an uncompared request");
  a_reinit_reload: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && out_nxt.reinit_request |=> settle_left_r == $past(cfg.settle_samples)
      && fail_run_r == '0)
    else $error("reinit did not reload the settle count");
`endif

endmodule

// ===== verif/asd_shake_checker.sv =====
// Checker that predicts every shake detector result and compares it on the result channel.
`timescale 1ns / 1ps
module asd_shake_checker import asd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_read_ok,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  input  logic [TICK_W-1:0]        in_now_tick,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     out_shake,
  input  logic                     out_reinit_request,
  input  logic [DELTA_W-1:0]       out_motion_delta,
  input  logic                     out_settling,
  output int                       mismatches,
  output int                       verdicts_owed
);

  cfg_t                     regs;
  logic signed [AXIS_W-1:0] last_x;
  logic signed [AXIS_W-1:0] last_y;
  logic signed [AXIS_W-1:0] last_z;
  logic                     have_last;
  logic [CNT_W-1:0]         settle_left;
  logic [CNT_W-1:0]         hit_run;
  logic [CNT_W-1:0]         fail_run;
  logic [TICK_W-1:0]        prior_shake_tick;
  result_t                  sample_verdicts[$];
  int                       errors;

  function automatic logic [DELTA_W-1:0] axis_gap(input logic signed [AXIS_W-1:0] a,
                                                  input logic signed [AXIS_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) begin
      d = -d;
    end
    return DELTA_W'(d);
  endfunction

  function automatic result_t judge_sample(input logic                     ok,
                                           input logic signed [AXIS_W-1:0] x,
                                           input logic signed [AXIS_W-1:0] y,
                                           input logic signed [AXIS_W-1:0] z,
                                           input logic [TICK_W-1:0]        tick);
    result_t            r;
    logic [DELTA_W-1:0] delta;
    logic               cool;
    r = '0;
    if (!ok) begin
      if (fail_run != CNT_MAX) begin
        fail_run++;
      end
      if (fail_run >= regs.failure_limit) begin
        r.reinit_request = 1'b1;
        fail_run = '0;
        settle_left = regs.settle_samples;
      end
      have_last = 1'b0;
      hit_run = '0;
    end else begin
      fail_run = '0;
      if (settle_left != '0) begin
        settle_left--;
        r.settling = 1'b1;
      end else if (have_last) begin
        delta = axis_gap(x, last_x) + axis_gap(y, last_y) + axis_gap(z, last_z);
        r.motion_delta = delta;
        cool = (tick - prior_shake_tick) >= regs.cooldown_ticks;
        if (delta >= regs.delta_threshold) begin
          if (hit_run != CNT_MAX) begin
            hit_run++;
          end
        end else begin
          hit_run = '0;
        end
        if (hit_run >= regs.required_hits && cool) begin
          r.shake = 1'b1;
          prior_shake_tick = tick;
          hit_run = '0;
        end
      end
      last_x = x;
      last_y = y;
      last_z = z;
      have_last = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    result_t got;
    result_t want;
    if (!rst_n) begin
      regs = '{delta_threshold: RST_DELTA_THRESHOLD, required_hits: RST_REQUIRED_HITS,
               cooldown_ticks: RST_COOLDOWN_TICKS, settle_samples: RST_SETTLE_SAMPLES,
               failure_limit: RST_FAILURE_LIMIT};
      last_x = '0;
      last_y = '0;
      last_z = '0;
      have_last = 1'b0;
      settle_left = RST_SETTLE_SAMPLES;
      hit_run = '0;
      fail_run = '0;
      prior_shake_tick = '0;
      sample_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELTA_THRESHOLD: regs.delta_threshold = cfg_wdata[DELTA_W-1:0];
          CFG_REQUIRED_HITS:   regs.required_hits = cfg_wdata[CNT_W-1:0];
          CFG_COOLDOWN_TICKS:  regs.cooldown_ticks = cfg_wdata[TICK_W-1:0];
          CFG_SETTLE_SAMPLES:  regs.settle_samples = cfg_wdata[CNT_W-1:0];
          CFG_FAILURE_LIMIT:   regs.failure_limit = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{shake: out_shake, reinit_request: out_reinit_request,
                motion_delta: out_motion_delta, settling: out_settling};
        if (sample_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with no request pending:", $time);
            $display("%0t:   shake=%0b reinit=%0b delta=%0d settling=%0b",
                     $time, got.shake, got.reinit_request, got.motion_delta, got.settling);
          end
        end else begin
          want = sample_verdicts.pop_front();
          if (got.shake !== want.shake || got.reinit_request !== want.reinit_request ||
              got.motion_delta !== want.motion_delta || got.settling !== want.settling) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch: expected shake=%0b reinit=%0b delta=%0d settling=%0b",
                       $time, want.shake, want.reinit_request, want.motion_delta, want.settling);
              $display("%0t:           actual   shake=%0b reinit=%0b delta=%0d settling=%0b",
                       $time, got.shake, got.reinit_request, got.motion_delta, got.settling);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        sample_verdicts.push_back(judge_sample(in_read_ok, in_accel_x, in_accel_y, in_accel_z,
                                               in_now_tick));
      end
    end
    mismatches <= errors;
    verdicts_owed <= sample_verdicts.size();
  end

endmodule

// ===== verif/tb_accel_shake_detector.sv =====
// Testbench top for the shake detector: request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb_accel_shake_detector;
  import asd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 250;
  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 100;

  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7FFF;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = 16'sh8000;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_read_ok;
  logic signed [AXIS_W-1:0] in_accel_x;
  logic signed [AXIS_W-1:0] in_accel_y;
  logic signed [AXIS_W-1:0] in_accel_z;
  logic [TICK_W-1:0]        in_now_tick;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_shake;
  logic                     out_reinit_request;
  logic [DELTA_W-1:0]       out_motion_delta;
  logic                     out_settling;
  int                       mismatches;
  int                       verdicts_owed;

  logic [TICK_W-1:0] tick_now;
  bit                tx_lazy;
  bit                rx_lazy;
  bit                hold_off_now;
  int                idle_cycles;

  accel_shake_detector u_top (.*);

  asd_shake_checker u_check (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("accel_shake_detector test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void step_tick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      tick_now += $urandom_range(0, 400);
    end else if (r < 95) begin
      tick_now += $urandom_range(400, 5000);
    end else begin
      tick_now += $urandom;
    end
  endfunction

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (hold_off_now) begin
        hold_off_now = 1'b0;
        stall_left = HOLDOFF_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (rx_lazy && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer(input logic ok, input logic signed [AXIS_W-1:0] x,
                       input logic signed [AXIS_W-1:0] y, input logic signed [AXIS_W-1:0] z,
                       input logic [TICK_W-1:0] tick);
    int gap;
    in_valid <= 1'b1;
    in_read_ok <= ok;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    in_now_tick <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = tx_lazy ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Bits above each register's width carry junk that the block must drop.
  task automatic configure(input logic [DELTA_W-1:0] thr, input logic [CNT_W-1:0] hits,
                           input logic [TICK_W-1:0] cool, input logic [CNT_W-1:0] settle,
                           input logic [CNT_W-1:0] flim);
    drain();
    repeat (2) @(posedge clk);
    write_reg(CFG_DELTA_THRESHOLD, (CFG_W'($urandom) << DELTA_W) | CFG_W'(thr));
    write_reg(CFG_REQUIRED_HITS, (CFG_W'($urandom) << CNT_W) | CFG_W'(hits));
    write_reg(CFG_COOLDOWN_TICKS, CFG_W'(cool));
    write_reg(CFG_SETTLE_SAMPLES, (CFG_W'($urandom) << CNT_W) | CFG_W'(settle));
    write_reg(CFG_FAILURE_LIMIT, (CFG_W'($urandom) << CNT_W) | CFG_W'(flim));
    cfg_we <= 1'b0;
  endtask

  // Bursts of calm jitter, swings between two far points, random noise and failed reads.
  task automatic stream_samples(input int n);
    int                       left;
    int                       len;
    int                       kind;
    int                       jit;
    int                       amp;
    logic signed [AXIS_W-1:0] bx;
    logic signed [AXIS_W-1:0] by;
    logic signed [AXIS_W-1:0] bz;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 12);
      if (len > left) begin
        len = left;
      end
      bx = AXIS_W'($urandom);
      by = AXIS_W'($urandom);
      bz = AXIS_W'($urandom);
      jit = $urandom_range(0, 3000);
      amp = $urandom_range(0, 32767);
      for (int i = 0; i < len; i++) begin
        step_tick();
        if (kind >= 8 || $urandom_range(0, 39) == 0) begin
          offer(1'b0, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom), tick_now);
        end else if (kind < 4) begin
          offer(1'b1, bx + AXIS_W'($urandom_range(0, 2 * jit) - jit),
                by + AXIS_W'($urandom_range(0, 2 * jit) - jit),
                bz + AXIS_W'($urandom_range(0, 2 * jit) - jit), tick_now);
        end else if (kind < 6) begin
          offer(1'b1, i[0] ? bx + AXIS_W'(amp) : bx - AXIS_W'(amp),
                i[0] ? by - AXIS_W'(amp) : by + AXIS_W'(amp),
                i[0] ? bz + AXIS_W'(amp) : bz - AXIS_W'(amp), tick_now);
        end else begin
          offer(1'b1, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom), tick_now);
        end
      end
      left -= len;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DELTA_THRESHOLD;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_read_ok <= 1'b0;
    in_accel_x <= '0;
    in_accel_y <= '0;
    in_accel_z <= '0;
    in_now_tick <= '0;
    tick_now = '0;
    tx_lazy = 1'b0;
    rx_lazy = 1'b0;
    hold_off_now = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a failed read, the settle run, then a full-scale shake.
    rx_lazy = 1'b1;
    offer(1'b0, AXIS_MIN, AXIS_MAX, AXIS_MIN, '0);
    for (int i = 0; i < 10; i++) begin
      offer(1'b1, i[0] ? AXIS_MAX : AXIS_MIN, i[0] ? AXIS_MAX : AXIS_MIN,
            i[0] ? AXIS_MAX : AXIS_MIN, TICK_W'(10 * i));
    end
    offer(1'b1, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd100);
    offer(1'b1, AXIS_MAX, AXIS_MAX, AXIS_MAX, 32'd200);
    offer(1'b1, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd2000);
    offer(1'b1, AXIS_MAX, AXIS_MAX, AXIS_MAX, 32'd2100);
    offer(1'b1, AXIS_MAX, AXIS_MAX - 16'sd1, AXIS_MAX, 32'd2200);
    repeat (3) offer(1'b0, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom), 32'd2300);
    offer(1'b1, 16'sd0, -16'sd1, 16'sd0, 32'hFFFF_FFFF);

    // The receiver holds off while requests keep coming, so the block must stall its input.
    tick_now = 32'd3000;
    hold_off_now = 1'b1;
    stream_samples(30);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure('0, CNT_MAX, 32'hFFFF_FFFF, '0, 8'd1);
        1: configure({DELTA_W{1'b1}}, 8'd1, '0, CNT_MAX, CNT_MAX);
        2: configure(DELTA_W'($urandom_range(500, 20000)), '0, $urandom_range(0, 2000),
                     CNT_W'($urandom_range(0, 4)), '0);
        default: configure($urandom_range(0, 4) == 0 ? DELTA_W'($urandom_range(0, 500))
                           : DELTA_W'($urandom_range(1000, 120000)),
                           CNT_W'($urandom_range(1, 6)),
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000),
                           CNT_W'($urandom_range(0, 12)), CNT_W'($urandom_range(1, 5)));
      endcase
      tx_lazy = (p % 3 != 2) && $urandom_range(0, 3) != 0;
      rx_lazy = (p % 3 != 2) && $urandom_range(0, 3) != 0;
      if (p == 0) begin
        // A long unbroken run pushes the hit count to saturation.
        repeat (300) begin
          step_tick();
          offer(1'b1, AXIS_W'($urandom_range(0, 200)), AXIS_W'($urandom_range(0, 200)),
                AXIS_W'($urandom_range(0, 200)), tick_now);
        end
      end else if (p == 1) begin
        repeat (255) offer(1'b0, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                           tick_now);
        repeat (260) begin
          step_tick();
          offer(1'b1, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom), tick_now);
        end
      end
      stream_samples(PHASE_REQUESTS);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && verdicts_owed == 0) begin
      $display("accel_shake_detector test passed");
    end else begin
      $display("accel_shake_detector test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/asd_pkg.sv
rtl/asd_front.sv
rtl/asd_queue.sv
rtl/asd_back.sv
rtl/accel_shake_detector.sv
verif/asd_shake_checker.sv
verif/tb_accel_shake_detector.sv
